// ===== rtl/core/s27ag_pkg.sv =====
// shared types and constants of the 27-point stencil address generator
package s27ag_pkg;

	localparam int ADDR_W     = 37;
	localparam int COORD_W    = 10;
	localparam int EXT_W      = 11;
	localparam int EB_W       = 7;
	localparam int ITER_W     = 16;
	localparam int EBX_W      = EXT_W + EB_W;
	localparam int PLANE_W    = 2 * EXT_W;
	localparam int EBP_W      = PLANE_W + EB_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ACC_W      = 5;
	localparam int SETTLE_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_X        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Y        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Z        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_PLANE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_PLANE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT    = 3'd6;

	localparam logic [EXT_W-1:0]   RST_GRID      = 11'd10;
	localparam logic [EB_W-1:0]    RST_EB        = 7'd8;
	localparam logic [COORD_W-1:0] RST_START     = 10'd0;
	localparam logic [EXT_W-1:0]   RST_END_PLANE = 11'd10;
	localparam logic [ITER_W-1:0]  RST_ITER      = 16'd1;

	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

	localparam logic [ACC_W-1:0] LAST_READ = 5'd26;
	localparam logic [ACC_W-1:0] WRITE_IDX = 5'd27;

	typedef struct packed {
		logic               fin;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} job_t;

	typedef struct packed {
		logic               settled;
		logic               start_wr;
		logic [COORD_W-1:0] start_new;
		logic [COORD_W-1:0] start_plane;
		logic [EXT_W-1:0]   grid_x;
		logic [EXT_W-1:0]   grid_y;
		logic [EXT_W-1:0]   end_plane;
		logic [ITER_W-1:0]  iter_count;
	} fcfg_t;

	typedef struct packed {
		logic [EB_W-1:0]   eb;
		logic [EBX_W-1:0]  ebx;
		logic [EBP_W-1:0]  ebplane;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] stp_y;
		logic [ADDR_W-1:0] stp_z;
		logic [ADDR_W-1:0] off;
	} bcfg_t;

endpackage

// ===== rtl/core/s27ag_if.sv =====
// request and result channel interfaces
interface s27ag_req_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink (input valid, input advance, output ready);
endinterface

interface s27ag_rsp_if;
	logic        valid;
	logic        ready;
	logic [36:0] address;
	logic        is_write;
	logic        last_of_run;
	logic        finished;

	modport source (output valid, output address, output is_write, output last_of_run,
		output finished, input ready);
	modport sink (input valid, input address, input is_write, input last_of_run,
		input finished, output ready);
endinterface

// ===== rtl/core/s27ag_cfg.sv =====
// configuration registers and derived address step products
module s27ag_cfg import s27ag_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output fcfg_t                 fcfg,
	output bcfg_t                 bcfg
);

	logic [EXT_W-1:0]    grid_x_q, grid_y_q, grid_z_q, end_plane_q;
	logic [EB_W-1:0]     eb_q;
	logic [COORD_W-1:0]  start_q;
	logic [ITER_W-1:0]   iter_q;
	logic [SETTLE_W-1:0] settle_q;

	logic [EBX_W-1:0]    ebx_q;
	logic [PLANE_W-1:0]  plane_q;
	logic [EBP_W-1:0]    ebplane_q;
	logic [ADDR_W-1:0]   base_q, stp_y_q, stp_z_q, off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q    <= RST_GRID;
			grid_y_q    <= RST_GRID;
			grid_z_q    <= RST_GRID;
			eb_q        <= RST_EB;
			start_q     <= RST_START;
			end_plane_q <= RST_END_PLANE;
			iter_q      <= RST_ITER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_X:        grid_x_q    <= cfg_data[EXT_W-1:0];
				REG_GRID_Y:        grid_y_q    <= cfg_data[EXT_W-1:0];
				REG_GRID_Z:        grid_z_q    <= cfg_data[EXT_W-1:0];
				REG_ELEMENT_BYTES: eb_q        <= cfg_data[EB_W-1:0];
				REG_START_PLANE:   start_q     <= cfg_data[COORD_W-1:0];
				REG_END_PLANE:     end_plane_q <= cfg_data[EXT_W-1:0];
				REG_ITER_COUNT:    iter_q      <= cfg_data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// derived products settle after any write; a countdown holds settled low until then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		ebx_q     <= EBX_W'(grid_x_q) * EBX_W'(eb_q);
		plane_q   <= PLANE_W'(grid_x_q) * PLANE_W'(grid_y_q);
		ebplane_q <= EBP_W'(plane_q) * EBP_W'(eb_q);
		base_q    <= ADDR_W'(ebplane_q) * ADDR_W'(grid_z_q);
		stp_y_q   <= ADDR_W'(ebx_q) - (ADDR_W'(eb_q) << 1);
		stp_z_q   <= ADDR_W'(ebplane_q) - (ADDR_W'(ebx_q) << 1) - (ADDR_W'(eb_q) << 1);
		off_q     <= ADDR_W'(ebplane_q) + ADDR_W'(ebx_q) + ADDR_W'(eb_q);
	end

	always_comb begin
		fcfg.settled     = (settle_q == '0) && !cfg_we;
		fcfg.start_wr    = cfg_we && (cfg_index == REG_START_PLANE);
		fcfg.start_new   = cfg_data[COORD_W-1:0];
		fcfg.start_plane = start_q;
		fcfg.grid_x      = grid_x_q;
		fcfg.grid_y      = grid_y_q;
		fcfg.end_plane   = end_plane_q;
		fcfg.iter_count  = iter_q;
		bcfg.eb          = eb_q;
		bcfg.ebx         = ebx_q;
		bcfg.ebplane     = ebplane_q;
		bcfg.base        = base_q;
		bcfg.stp_y       = stp_y_q;
		bcfg.stp_z       = stp_z_q;
		bcfg.off         = off_q;
	end

endmodule

// ===== rtl/core/s27ag_front.sv =====
// request intake: classifies requests and walks the interior points
module s27ag_front import s27ag_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  fcfg_t fcfg,
	s27ag_req_if.sink req,
	output logic  push_valid,
	input  logic  push_ready,
	output job_t  push_job
);

	logic [COORD_W-1:0] x_q, y_q, z_q;
	logic [ITER_W-1:0]  sweep_q;

	logic             accept, fin, step;
	logic [EXT_W-1:0] bound_x, bound_y, bound_z;
	logic             wrap_x, wrap_y, wrap_z;

	assign req.ready  = push_ready && fcfg.settled;
	assign accept     = req.valid && req.ready;
	assign fin        = sweep_q >= fcfg.iter_count;
	assign push_valid = accept && req.advance;
	assign step       = push_valid && !fin;

	always_comb begin
		bound_x = (fcfg.grid_x != '0) ? fcfg.grid_x - EXT_W'(1) : '0;
		bound_y = (fcfg.grid_y != '0) ? fcfg.grid_y - EXT_W'(1) : '0;
		bound_z = (fcfg.end_plane >= EXT_W'(2)) ? fcfg.end_plane - EXT_W'(2) : '0;
		wrap_x  = (EXT_W'(x_q) + EXT_W'(1)) >= bound_x;
		wrap_y  = (EXT_W'(y_q) + EXT_W'(1)) >= bound_y;
		wrap_z  = EXT_W'(z_q) >= bound_z;
		push_job.fin = fin;
		push_job.x   = x_q;
		push_job.y   = y_q;
		push_job.z   = z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= COORD_W'(1);
			y_q     <= COORD_W'(1);
			z_q     <= RST_START + COORD_W'(1);
			sweep_q <= '0;
		end else if (fcfg.start_wr) begin
			z_q <= fcfg.start_new + COORD_W'(1);
		end else if (step) begin
			if (!wrap_x) begin
				x_q <= x_q + COORD_W'(1);
			end else begin
				x_q <= COORD_W'(1);
				if (!wrap_y) begin
					y_q <= y_q + COORD_W'(1);
				end else begin
					y_q <= COORD_W'(1);
					if (!wrap_z) begin
						z_q <= z_q + COORD_W'(1);
					end else begin
						z_q     <= fcfg.start_plane + COORD_W'(1);
						sweep_q <= sweep_q + ITER_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/s27ag_queue.sv =====
// small job queue between intake and address sequencer
module s27ag_queue import s27ag_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/s27ag_back.sv =====
// address sequencer: base products, setup and the 28-access walk
module s27ag_back import s27ag_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  bcfg_t bcfg,
	input  logic  pop_valid,
	output logic  pop_ready,
	input  job_t  pop_job,
	s27ag_rsp_if.source rsp
);

	logic              valid_s1, fin_s1;
	logic [ADDR_W-1:0] pz_s1, py_s1, px_s1;
	logic              valid_s2, fin_s2;
	logic [ADDR_W-1:0] center_s2, start_s2;

	logic              busy_q, fin_q;
	logic [ACC_W-1:0]  cnt_q;
	logic [1:0]        dx_q, dy_q;
	logic [ADDR_W-1:0] addr_q, wr_q, step;

	logic take, em_last, em_take, em_load, s2_load, s1_free;

	assign take      = busy_q && rsp.ready;
	assign em_last   = fin_q || (cnt_q == WRITE_IDX);
	assign em_take   = take && em_last;
	assign em_load   = valid_s2 && (!busy_q || em_take);
	assign s2_load   = valid_s1 && (!valid_s2 || em_load);
	assign s1_free   = !valid_s1 || s2_load;
	assign pop_ready = s1_free;

	always_comb begin
		if (dx_q != 2'd2) begin
			step = ADDR_W'(bcfg.eb);
		end else if (dy_q != 2'd2) begin
			step = bcfg.stp_y;
		end else begin
			step = bcfg.stp_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			busy_q   <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= pop_valid;
			end
			if (!valid_s2 || em_load) begin
				valid_s2 <= valid_s1;
			end
			if (em_load) begin
				busy_q <= 1'b1;
			end else if (em_take) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			fin_s1 <= pop_job.fin;
			pz_s1  <= ADDR_W'(pop_job.z) * ADDR_W'(bcfg.ebplane);
			py_s1  <= ADDR_W'(pop_job.y) * ADDR_W'(bcfg.ebx);
			px_s1  <= ADDR_W'(pop_job.x) * ADDR_W'(bcfg.eb);
		end
		if (s2_load) begin
			fin_s2    <= fin_s1;
			center_s2 <= pz_s1 + py_s1 + px_s1;
			start_s2  <= pz_s1 + py_s1 + px_s1 - bcfg.off;
		end
		if (em_load) begin
			fin_q  <= fin_s2;
			cnt_q  <= '0;
			dx_q   <= 2'd0;
			dy_q   <= 2'd0;
			addr_q <= fin_s2 ? '0 : start_s2;
			wr_q   <= bcfg.base + center_s2;
		end else if (take && !em_last) begin
			cnt_q <= cnt_q + ACC_W'(1);
			if (cnt_q == LAST_READ) begin
				addr_q <= wr_q;
			end else begin
				addr_q <= addr_q + step;
			end
			if (dx_q == 2'd2) begin
				dx_q <= 2'd0;
				dy_q <= (dy_q == 2'd2) ? 2'd0 : dy_q + 2'd1;
			end else begin
				dx_q <= dx_q + 2'd1;
			end
		end
	end

	assign rsp.valid       = busy_q;
	assign rsp.address     = addr_q;
	assign rsp.is_write    = !fin_q && (cnt_q == WRITE_IDX);
	assign rsp.last_of_run = em_last;
	assign rsp.finished    = fin_q;

`ifndef SYNTHESIS
	a_fin_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && fin_q |-> cnt_q == '0)
		else $error("finished result not at access zero");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= WRITE_IDX)
		else $error("access counter past the write");

	a_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		take && !fin_q && cnt_q == LAST_READ |=> rsp.address == $past(wr_q))
		else $error("write address not loaded after last read");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !busy_q |=> busy_q)
		else $error("prepared job not started by idle sequencer");
`endif

endmodule

// ===== rtl/core/stencil27_address_generator.sv =====
// top level of the 27-point stencil address generator
// usage:
//  - req channel: one request per advance; advance 0 is taken and gives nothing
//  - rsp channel: per point 27 neighbor reads (dz, dy, dx from -1 to +1, dx
//    fastest) then one write with last_of_run set; after all sweeps each
//    request gives a single result with finished and last_of_run set
//  - cfg port: write enable, register index and data; write only while idle
//  - first result: an accepted request passes the queue, the product stage
//    and the setup stage before the walk sequencer loads it
//  - the walk sequencer gives one access per cycle while rsp is ready, 28
//    accesses per point; once finished, results follow back to back
//  - requests queue up while the sequencer walks, so intake and setup of the
//    next point overlap the current walk
//  - after reset and after every config write req.ready stays low
//    while the step products settle
//  - a stalled rsp holds the current access; intake stops once the queue and
//    setup stages are full
module stencil27_address_generator import s27ag_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	s27ag_req_if.sink             req,
	s27ag_rsp_if.source           rsp
);

	fcfg_t fcfg;
	bcfg_t bcfg;
	logic  push_valid, push_ready, pop_valid, pop_ready;
	job_t  push_job, pop_job;

	s27ag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fcfg      (fcfg),
		.bcfg      (bcfg)
	);

	s27ag_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fcfg       (fcfg),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	s27ag_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	s27ag_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.bcfg      (bcfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.rsp       (rsp)
	);

endmodule
